FILE: hdl/iba_pkg.sv
package iba_pkg;

	// Field widths of the item payloads and the configuration register.
	localparam int ID_W     = 17;
	localparam int BASE_W   = 16;
	localparam int STATUS_W = 2;

	// Bitmap rows held in the RAM: 128 bits, scanned one row per cycle.
	localparam int ROW_BITS  = 128;
	localparam int ROW_BYTES = ROW_BITS / 8;
	localparam int BIT_W     = 7;
	localparam int BYTE_W    = 4;

	// Command codes.
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Position of the lowest clear bit in a row, found first by byte and then
	// by bit inside that byte. Only meaningful when the row has a clear bit.
	function automatic logic [BIT_W-1:0] lowest_clear(input logic [ROW_BITS-1:0] row);
		logic [BYTE_W-1:0] byte_sel;
		logic [2:0]        bit_sel;
		logic [7:0]        byte_val;
		byte_sel = '0;
		bit_sel  = '0;
		for (int k = ROW_BYTES - 1; k >= 0; k--) begin
			if (!(&row[8*k +: 8])) begin
				byte_sel = BYTE_W'(k);
			end
		end
		byte_val = row[8*byte_sel +: 8];
		for (int b = 7; b >= 0; b--) begin
			if (!byte_val[b]) begin
				bit_sel = 3'(b);
			end
		end
		return {byte_sel, bit_sel};
	endfunction

endpackage

FILE: hdl/iba_req_if.sv
interface iba_req_if;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [iba_pkg::ID_W-1:0] release_id;

	modport source(output valid, cmd, release_id, input ready);
	modport sink(input valid, cmd, release_id, output ready);
endinterface

FILE: hdl/iba_rsp_if.sv
interface iba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [iba_pkg::ID_W-1:0]     granted_id;
	logic [iba_pkg::STATUS_W-1:0] status;

	modport source(output valid, granted_id, status, input ready);
	modport sink(input valid, granted_id, status, output ready);
endinterface

FILE: hdl/id_bitmap_allocator_core.sv
// Allocate: the 128-bit bitmap rows are read in turn from row 0 until one with a free
// identifier is found, and the lowest free identifier is granted; a full pool scans every row.
// Release: its row is read, the bit cleared and the row written back; an identifier
// outside the pool is answered without a bitmap access. One item is in work at a time,
// and the next is taken once its result is handed on to the output register.
// Reset clears the per-row valid flags (every identifier free), sets the base to 1.
module id_bitmap_allocator_core #(
	parameter int ID_BYTES = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [iba_pkg::BASE_W-1:0]  cfg_wdata,
	iba_req_if.sink                     req,
	iba_rsp_if.source                   rsp
);
	import iba_pkg::*;

	localparam int ID_BITS   = ID_BYTES * 8;
	localparam int NROWS     = (ID_BYTES + ROW_BYTES - 1) / ROW_BYTES;
	localparam int ROW_AW    = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int CNT_W     = $clog2(NROWS + 1);
	localparam int IDX_W     = ROW_AW + BIT_W;
	localparam int LAST_BITS = ID_BITS - (NROWS - 1) * ROW_BITS;

	localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(NROWS - 1);
	localparam logic [CNT_W-1:0]  ROW_COUNT  = CNT_W'(NROWS);
	localparam logic [ID_W-1:0]   POOL_SIZE  = ID_W'(ID_BITS);
	localparam logic [ROW_BITS-1:0] ONE_ROW  = {{(ROW_BITS-1){1'b0}}, 1'b1};
	// Bits past the end of the pool in the last row read as taken.
	localparam logic [ROW_BITS-1:0] LAST_PAD = ~((ONE_ROW << LAST_BITS) - ONE_ROW);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_REL_RD = 3'd2;
	localparam logic [2:0] S_REL_WR = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]          state_q;
	logic [BASE_W-1:0]   base_q;
	logic [NROWS-1:0]    row_vld_q;
	logic [CNT_W-1:0]    rd_row_q;
	logic [ROW_AW-1:0]   chk_row_q;
	logic                pend_q;
	logic [IDX_W-1:0]    off_q;
	logic [ID_W-1:0]     res_id_q;
	logic [STATUS_W-1:0] res_st_q;
	logic                out_vld_q;
	logic [ID_W-1:0]     out_id_q;
	logic [STATUS_W-1:0] out_st_q;

	logic                ram_we;
	logic [ROW_AW-1:0]   ram_waddr;
	logic [ROW_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [ROW_AW-1:0]   ram_raddr;
	logic [ROW_BITS-1:0] ram_rdata;

	logic                accept;
	logic [ID_W:0]       rel_diff;
	logic                rel_bad;
	logic [ROW_AW-1:0]   cur_row;
	logic [ROW_BITS-1:0] cur_data;
	logic [ROW_BITS-1:0] scan_data;
	logic                row_free;
	logic [BIT_W-1:0]    free_bit;
	logic [ID_W-1:0]     grant_sum;
	logic                issue;
	logic                load_out;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// Range check of a release against the base and the pool size.
	assign rel_diff = {1'b0, req.release_id} - {{(ID_W + 1 - BASE_W){1'b0}}, base_q};
	assign rel_bad  = rel_diff[ID_W] || (rel_diff[ID_W-1:0] >= POOL_SIZE);

	// The row under examination; a row never written reads as all free.
	assign cur_row   = (state_q == S_ALLOC) ? chk_row_q : off_q[BIT_W +: ROW_AW];
	assign cur_data  = row_vld_q[cur_row] ? ram_rdata : '0;
	assign scan_data = cur_data | ((cur_row == LAST_ROW) ? LAST_PAD : '0);
	assign row_free  = !(&scan_data);
	assign free_bit  = lowest_clear(scan_data);
	assign grant_sum = ID_W'({chk_row_q, free_bit}) + ID_W'(base_q);

	assign issue    = (state_q == S_ALLOC) && !(pend_q && (row_free || chk_row_q == LAST_ROW))
		&& (rd_row_q < ROW_COUNT);
	assign load_out = (state_q == S_RESP) && (!out_vld_q || rsp.ready);

	// RAM port control: reads during the scan and the release, at most one write at the end.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_row_q[ROW_AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = cur_row;
		ram_wdata = cur_data;
		unique case (state_q)
			S_ALLOC: begin
				ram_re = issue;
				if (pend_q && row_free) begin
					ram_we    = 1'b1;
					ram_wdata = cur_data | (ONE_ROW << free_bit);
				end
			end
			S_REL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = off_q[BIT_W +: ROW_AW];
			end
			S_REL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = cur_data & ~(ONE_ROW << off_q[BIT_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	iba_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(NROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_W'(1);
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Sequencer for the row scan and the read-modify-write of a release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_vld_q <= '0;
			rd_row_q  <= '0;
			chk_row_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_row_q <= '0;
						pend_q   <= 1'b0;
						if (req.cmd == CMD_ALLOC) begin
							state_q <= S_ALLOC;
						end else if (rel_bad) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_REL_RD;
						end
					end
				end
				S_ALLOC: begin
					if (pend_q && (row_free || chk_row_q == LAST_ROW)) begin
						state_q <= S_RESP;
						pend_q  <= 1'b0;
					end else begin
						pend_q <= issue;
						if (issue) begin
							chk_row_q <= rd_row_q[ROW_AW-1:0];
							rd_row_q  <= rd_row_q + CNT_W'(1);
						end
					end
				end
				S_REL_RD: begin
					state_q <= S_REL_WR;
				end
				S_REL_WR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result of the item in work.
	always_ff @(posedge clk) begin
		if (accept) begin
			off_q    <= rel_diff[IDX_W-1:0];
			res_id_q <= '0;
			res_st_q <= (req.cmd == CMD_RELEASE && rel_bad) ? ST_RANGE : ST_OK;
		end else if (state_q == S_ALLOC && pend_q) begin
			if (row_free) begin
				res_id_q <= grant_sum;
				res_st_q <= ST_OK;
			end else if (chk_row_q == LAST_ROW) begin
				res_st_q <= ST_FULL;
			end
		end
	end

	// Output register; it holds a finished item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_id_q <= res_id_q;
			out_st_q <= res_st_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.granted_id = out_id_q;
	assign rsp.status     = out_st_q;

	// A new item reaches the output only from the response state.
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_RESP))
		else $error("output item loaded outside the response state");

	// The bitmap is written only at the end of an allocate or a release.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_ALLOC || state_q == S_REL_WR))
		else $error("bitmap write outside an allocate or release");

	// Only a successful allocate carries a nonzero identifier.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_st_q != ST_OK) |-> (out_id_q == '0))
		else $error("failed item carries an identifier");

	// The row being checked is always the one read just before.
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC && pend_q) |-> (CNT_W'(chk_row_q) + CNT_W'(1) == rd_row_q))
		else $error("scan row out of step with the read pointer");

	// The scan never reads past the last row.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> (rd_row_q <= ROW_COUNT))
		else $error("scan pointer past the last row");

endmodule

FILE: hdl/iba_ram.sv
module iba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
